FILE: rtl/core/aabb_pkg.sv
// Package for the box overlap resolver: widths and beat types.
`default_nettype none
package aabb_pkg;

  localparam int CoordBits = 24;
  localparam int HalfBits  = CoordBits - 2;
  localparam int ReachBits = CoordBits - 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] body_x;
    logic signed [CoordBits-1:0] body_y;
    logic        [HalfBits-1:0]  body_half_w;
    logic        [HalfBits-1:0]  body_half_h;
    logic        [ReachBits-1:0] body_reach;
    logic signed [CoordBits-1:0] other_x;
    logic signed [CoordBits-1:0] other_y;
    logic        [HalfBits-1:0]  other_half_w;
    logic        [HalfBits-1:0]  other_half_h;
    logic        [ReachBits-1:0] other_reach;
    logic                        either_trigger;
  } pair_beat_t;

  typedef struct packed {
    logic                        hit;
    logic signed [CoordBits-1:0] shift_x;
    logic signed [CoordBits-1:0] shift_y;
    logic                        stop_vx;
    logic                        stop_vy;
  } push_beat_t;

endpackage
`default_nettype wire

FILE: rtl/core/aabb_overlap_resolve.sv
// Box pair overlap test with minimum-axis push, three-stage pipeline.
//
// One pair is taken in every cycle (busy_o never rises) and its result shows on
// res_o for one cycle past in_vld_q, mid_vld_q, marked by res_valid_o. Stage one
// registers the pair; stage two forms the squared centre distances in two 25x25
// multipliers and the squared reach sum in one 24x24 multiplier, next to the
// interval test and the push; stage three adds the squares and compares them
// against the reach square, then zeroes the push if the coarse test fails. The
// receiver cannot stall, so every result must be taken in the cycle it is shown.
`default_nettype none
module aabb_overlap_resolve (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  aabb_pkg::pair_beat_t in_i,
  output logic                res_valid_o,
  output aabb_pkg::push_beat_t res_o
);
  import aabb_pkg::*;

  localparam int W1 = CoordBits + 1;
  localparam int W2 = CoordBits + 2;
  localparam int WQ = 2 * CoordBits + 2;
  localparam int WR = 2 * CoordBits;

  pair_beat_t in_q;
  logic       in_vld_q;

  logic [WQ-1:0] qx_q, qy_q;
  logic [WR-1:0] r2_q;
  push_beat_t    push_q;
  logic          mid_vld_q;

  // stage one: capture
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= in_i;
    end
  end

  // stage two: squares, intervals, push
  logic signed [W1-1:0] ddx, ddy;
  logic [W1-1:0]        adx, ady;
  logic [CoordBits-1:0] rs;
  logic [WQ-1:0]        qx_d, qy_d;
  logic [WR-1:0]        r2_d;

  logic signed [W1-1:0] bl, br, bt, bb, ol, orr, ot, ob;
  logic signed [W1-1:0] lft, rgt, top, bot;
  logic signed [W2-1:0] dep_x, dep_y;
  logic [ReachBits-1:0] px, py;
  logic signed [CoordBits-1:0] mag_x, mag_y;
  logic                 ovl;
  push_beat_t           push_d;

  assign ddx = W1'(in_q.other_x) - W1'(in_q.body_x);
  assign ddy = W1'(in_q.other_y) - W1'(in_q.body_y);
  assign adx = ddx[W1-1] ? W1'(-ddx) : W1'(ddx);
  assign ady = ddy[W1-1] ? W1'(-ddy) : W1'(ddy);
  assign rs  = CoordBits'(in_q.body_reach) + CoordBits'(in_q.other_reach);
  assign qx_d = WQ'(adx) * WQ'(adx);
  assign qy_d = WQ'(ady) * WQ'(ady);
  assign r2_d = WR'(rs) * WR'(rs);

  assign bl  = W1'(in_q.body_x)  - $signed(W1'(in_q.body_half_w));
  assign br  = W1'(in_q.body_x)  + $signed(W1'(in_q.body_half_w));
  assign bt  = W1'(in_q.body_y)  - $signed(W1'(in_q.body_half_h));
  assign bb  = W1'(in_q.body_y)  + $signed(W1'(in_q.body_half_h));
  assign ol  = W1'(in_q.other_x) - $signed(W1'(in_q.other_half_w));
  assign orr = W1'(in_q.other_x) + $signed(W1'(in_q.other_half_w));
  assign ot  = W1'(in_q.other_y) - $signed(W1'(in_q.other_half_h));
  assign ob  = W1'(in_q.other_y) + $signed(W1'(in_q.other_half_h));

  assign lft = (bl > ol) ? bl : ol;
  assign rgt = (br < orr) ? br : orr;
  assign top = (bt > ot) ? bt : ot;
  assign bot = (bb < ob) ? bb : ob;

  assign ovl   = (lft < rgt) && (top < bot);
  assign dep_x = W2'(rgt) - W2'(lft);
  assign dep_y = W2'(bot) - W2'(top);
  assign px    = ReachBits'(dep_x);
  assign py    = ReachBits'(dep_y);
  assign mag_x = $signed(CoordBits'(px));
  assign mag_y = $signed(CoordBits'(py));

  always_comb begin
    push_d = '0;
    if (ovl) begin
      push_d.hit = 1'b1;
      if (!in_q.either_trigger) begin
        if (dep_x < dep_y) begin
          push_d.shift_x = (in_q.body_x < in_q.other_x) ? -mag_x : mag_x;
          push_d.stop_vx = 1'b1;
        end else begin
          push_d.shift_y = (in_q.body_y < in_q.other_y) ? -mag_y : mag_y;
          push_d.stop_vy = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else begin
      mid_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      r2_q   <= r2_d;
      push_q <= push_d;
    end
  end

  // stage three: coarse distance test
  logic [WQ-1:0] d2;
  logic          near;

  assign d2   = qx_q + qy_q;
  assign near = d2 < WQ'(r2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_vld_q) begin
      res_o <= near ? push_q : '0;
    end
  end

  a_res_follows_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(mid_vld_q))
    else $error("result beat without a stage-two beat");

  a_mid_follows_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_vld_q |-> $past(in_vld_q))
    else $error("stage-two beat without a captured pair");

  a_push_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.stop_vx) |->
      (res_o.hit && !res_o.stop_vy && res_o.shift_y == '0 && res_o.shift_x != '0))
    else $error("x push inconsistent");

  a_push_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.stop_vy) |->
      (res_o.hit && res_o.shift_x == '0 && res_o.shift_y != '0))
    else $error("y push inconsistent");

  a_no_stray_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.stop_vx && !res_o.stop_vy) |->
      (res_o.shift_x == '0 && res_o.shift_y == '0))
    else $error("shift without a stopped axis");

endmodule
`default_nettype wire
